### hw/rtl/epipolar_transfer_error_macros.svh
// ----------------------------------------------------------------------------
// epipolar transfer error: assertion macros
// shared shorthand for clocked assertions with asynchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef EPIPOLAR_TRANSFER_ERROR_MACROS_SVH
`define EPIPOLAR_TRANSFER_ERROR_MACROS_SVH

// same-cycle implication
`define ETX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etx assertion failed");

// next-cycle implication
`define ETX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etx assertion failed");

`endif

### hw/rtl/etx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etx_pkg
// widths, types and helpers of the epipolar transfer error block
// ----------------------------------------------------------------------------
package etx_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COEF_WIDTH  = 20;
  localparam int COL_WIDTH   = 3 * COEF_WIDTH;
  localparam int FRAC_SHIFT  = 4;   // homogeneous one is raw 16
  localparam int ERR_WIDTH   = 32;
  localparam int CFG_IDX_WIDTH = 2;

  localparam int PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;
  localparam int LINE_WIDTH = PROD_WIDTH + 2;
  localparam int MUL_WIDTH  = LINE_WIDTH + COORD_WIDTH;
  localparam int DOT_WIDTH  = MUL_WIDTH + 2;
  localparam int NUM_WIDTH  = 2 * DOT_WIDTH;
  localparam int LSQ_WIDTH  = 2 * LINE_WIDTH;
  localparam int DEN_WIDTH  = LSQ_WIDTH + 1;

  // split operands for the squaring multipliers
  localparam int LINE_LO = LINE_WIDTH / 2;
  localparam int LINE_HI = LINE_WIDTH - LINE_LO;
  localparam int LHH_W   = 2 * LINE_HI;
  localparam int LHL_W   = LINE_WIDTH;
  localparam int LLL_W   = 2 * LINE_LO;
  localparam int DOT_LO  = DOT_WIDTH / 2;
  localparam int DOT_HI  = DOT_WIDTH - DOT_LO;
  localparam int DHH_W   = 2 * DOT_HI;
  localparam int DHL_W   = DOT_WIDTH;
  localparam int DLL_W   = 2 * DOT_LO;

  localparam int QUO_STEPS   = ERR_WIDTH;
  localparam int LANE_STAGES = 6 + QUO_STEPS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_F_COL0,
    REG_F_COL1,
    REG_F_COL2,
    REG_SYM_MODE
  } cfg_reg_e;

  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [LINE_WIDTH-1:0]  line_t;

  // one line and the point measured against it
  typedef struct packed {
    line_t  a;
    line_t  b;
    line_t  c;
    coord_t px;
    coord_t py;
  } lane_in_t;

  typedef struct packed {
    lane_in_t side1;  // line from first point, second point
    lane_in_t side0;  // line from second point, first point
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [ERR_WIDTH-1:0] err;
    logic                 deg;
  } lane_res_t;

  typedef struct packed {
    logic [ERR_WIDTH-1:0] err;
    logic                 side;
    logic                 deg;
  } result_t;

  function automatic coef_t coef_at(input logic [COL_WIDTH-1:0] col, input int unsigned row);
    return coef_t'(col[row*COEF_WIDTH +: COEF_WIDTH]);
  endfunction

endpackage

### hw/rtl/epipolar_transfer_error.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epipolar_transfer_error
// squared epipolar distance of point correspondences under a fixed-point
// fundamental matrix, optionally symmetric
// ----------------------------------------------------------------------------
// usage:
// - input side is a queue: an item transfers on a clock edge with push high
//   and full low; fields are x/y of the first and second image point, Q12.4
// - result side is a queue: the oldest result sits on sq_error_o,
//   error_side_o and degenerate_o while empty is low and transfers on an edge
//   with pop high
// - one item per cycle is sustained while the receiver pops; a result passes
//   from its input transfer through the two line stages, the job queue,
//   the five multiply stages, the saturation check and the 32-stage divider
// - a stalled receiver freezes the result register and the divider pipeline;
//   the front keeps filling its two-entry job queue, then raises full
// - reset clears all valid state and the matrix and mode registers to zero
// - configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (column 0, 1, 2 of the matrix, then symmetric mode); write only when idle
// ----------------------------------------------------------------------------
module epipolar_transfer_error import etx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COL_WIDTH-1:0]     cfg_data_i,
  // correspondence input
  input  logic                     push,
  output logic                     full,
  input  coord_t                   x_first_i,
  input  coord_t                   y_first_i,
  input  coord_t                   x_second_i,
  input  coord_t                   y_second_i,
  // results
  input  logic                     pop,
  output logic                     empty,
  output logic [ERR_WIDTH-1:0]     sq_error_o,
  output logic                     error_side_o,
  output logic                     degenerate_o
);

  logic [COL_WIDTH-1:0] f_col0_q, f_col1_q, f_col2_q;
  logic                 sym_q;
  logic                 front_ready;
  logic                 q_push, q_pop;
  job_t                 q_wdata, q_rdata;
  queue_stat_t          q_stat;
  result_t              res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_col0_q <= '0;
      f_col1_q <= '0;
      f_col2_q <= '0;
      sym_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_F_COL0:   f_col0_q <= cfg_data_i;
        REG_F_COL1:   f_col1_q <= cfg_data_i;
        REG_F_COL2:   f_col2_q <= cfg_data_i;
        REG_SYM_MODE: sym_q    <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  // front: accept and form both lines
  etx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_ready_o (front_ready),
    .x_first_i  (x_first_i),
    .y_first_i  (y_first_i),
    .x_second_i (x_second_i),
    .y_second_i (y_second_i),
    .f_col0_i   (f_col0_q),
    .f_col1_i   (f_col1_q),
    .f_col2_i   (f_col2_q),
    .q_full_i   (q_stat.full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  assign full = !front_ready;

  // job queue decouples line forming from the error lanes
  etx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  // back: distances, division, side selection, result register
  etx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_i       (sym_q),
    .q_stat_i    (q_stat),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .res_o       (res)
  );

  assign sq_error_o   = res.err;
  assign error_side_o = res.side;
  assign degenerate_o = res.deg;

endmodule

### hw/rtl/etx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etx_front
// accepts correspondences and forms both epipolar lines in two stages
// ----------------------------------------------------------------------------
module etx_front import etx_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  coord_t               x_first_i,
  input  coord_t               y_first_i,
  input  coord_t               x_second_i,
  input  coord_t               y_second_i,
  input  logic [COL_WIDTH-1:0] f_col0_i,
  input  logic [COL_WIDTH-1:0] f_col1_i,
  input  logic [COL_WIDTH-1:0] f_col2_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output job_t                 q_data_o
);

  logic [COL_WIDTH-1:0] col [3];
  coef_t  f [3][3];
  prod_t  t1_q [3][2];
  prod_t  t0_q [3][2];
  coord_t x1_q, y1_q, x2_q, y2_q;
  line_t  l1 [3];
  line_t  l0 [3];
  logic   v1_q, v2_q;
  logic   adv;
  job_t   job_q;

  assign col[0] = f_col0_i;
  assign col[1] = f_col1_i;
  assign col[2] = f_col2_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        f[r][c] = coef_at(col[c], r);
      end
    end
  end

  assign adv        = !v2_q || !q_full_i;
  assign in_ready_o = adv;
  assign q_push_o   = v2_q && !q_full_i;
  assign q_data_o   = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // stage one: coordinate products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        t1_q[k][0] <= PROD_WIDTH'(f[0][k]) * PROD_WIDTH'(x_first_i);
        t1_q[k][1] <= PROD_WIDTH'(f[1][k]) * PROD_WIDTH'(y_first_i);
        t0_q[k][0] <= PROD_WIDTH'(f[k][0]) * PROD_WIDTH'(x_second_i);
        t0_q[k][1] <= PROD_WIDTH'(f[k][1]) * PROD_WIDTH'(y_second_i);
      end
      x1_q <= x_first_i;
      y1_q <= y_first_i;
      x2_q <= x_second_i;
      y2_q <= y_second_i;
    end
  end

  // stage two: line sums, third coordinate is one
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      l1[k] = LINE_WIDTH'(t1_q[k][0]) + LINE_WIDTH'(t1_q[k][1])
            + (LINE_WIDTH'(f[2][k]) <<< FRAC_SHIFT);
      l0[k] = LINE_WIDTH'(t0_q[k][0]) + LINE_WIDTH'(t0_q[k][1])
            + (LINE_WIDTH'(f[k][2]) <<< FRAC_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      job_q.side1.a  <= l1[0];
      job_q.side1.b  <= l1[1];
      job_q.side1.c  <= l1[2];
      job_q.side1.px <= x2_q;
      job_q.side1.py <= y2_q;
      job_q.side0.a  <= l0[0];
      job_q.side0.b  <= l0[1];
      job_q.side0.c  <= l0[2];
      job_q.side0.px <= x1_q;
      job_q.side0.py <= y1_q;
    end
  end

endmodule

### hw/rtl/etx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etx_queue
// short queue of line jobs between front and back
// ----------------------------------------------------------------------------
module etx_queue import etx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        data_i,
  input  logic        pop_i,
  output job_t        data_o,
  output queue_stat_t stat_o
);

  `include "epipolar_transfer_error_macros.svh"

  job_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;
  logic                   do_push, do_pop;

  assign stat_o.full  = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ETX_ASSERT_IMPL(count_in_range, clk_i, rst_ni, 1'b1, cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
  `ETX_ASSERT_NEXT(push_fills, clk_i, rst_ni, do_push && !do_pop, !stat_o.empty)
  `ETX_ASSERT_NEXT(pop_frees, clk_i, rst_ni, do_pop && !do_push, !stat_o.full)

endmodule

### hw/rtl/etx_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etx_lane
// squared point-to-line distance: dot products, split squares, 32-step divider
// ----------------------------------------------------------------------------
module etx_lane import etx_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  lane_in_t  in_i,
  output lane_res_t res_o
);

  logic signed [MUL_WIDTH-1:0] ma_q, mb_q;
  line_t                       c1_q;
  logic [LINE_WIDTH-1:0]       a_mag, b_mag, a_mag_q, b_mag_q;

  logic signed [DOT_WIDTH-1:0] d_q;
  logic [LHH_W-1:0]            a_hh_q, b_hh_q;
  logic [LHL_W-1:0]            a_hl_q, b_hl_q;
  logic [LLL_W-1:0]            a_ll_q, b_ll_q;

  logic [DOT_WIDTH-1:0]        d_mag_q;
  logic [LSQ_WIDTH-1:0]        a_sq, b_sq;
  logic [DEN_WIDTH-1:0]        den3_q, den4_q, den5_q;

  logic [DHH_W-1:0]            d_hh_q;
  logic [DHL_W-1:0]            d_hl_q;
  logic [DLL_W-1:0]            d_ll_q;
  logic                        deg4_q, deg5_q;

  logic [NUM_WIDTH-1:0]        num_q;

  logic [NUM_WIDTH-1:0]        rem_q [QUO_STEPS];
  logic [DEN_WIDTH-1:0]        den_q [QUO_STEPS];
  logic [ERR_WIDTH-1:0]        quo_q [QUO_STEPS+1];
  logic                        sat_q [QUO_STEPS+1];
  logic                        deg_q [QUO_STEPS+1];

  assign a_mag = in_i.a[LINE_WIDTH-1] ? LINE_WIDTH'(-in_i.a) : LINE_WIDTH'(in_i.a);
  assign b_mag = in_i.b[LINE_WIDTH-1] ? LINE_WIDTH'(-in_i.b) : LINE_WIDTH'(in_i.b);

  // line normal squares from split partial products
  assign a_sq = (LSQ_WIDTH'(a_hh_q) << (2 * LINE_LO)) + (LSQ_WIDTH'(a_hl_q) << (LINE_LO + 1))
              + LSQ_WIDTH'(a_ll_q);
  assign b_sq = (LSQ_WIDTH'(b_hh_q) << (2 * LINE_LO)) + (LSQ_WIDTH'(b_hl_q) << (LINE_LO + 1))
              + LSQ_WIDTH'(b_ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // s1
      ma_q    <= MUL_WIDTH'(in_i.a) * MUL_WIDTH'(in_i.px);
      mb_q    <= MUL_WIDTH'(in_i.b) * MUL_WIDTH'(in_i.py);
      c1_q    <= in_i.c;
      a_mag_q <= a_mag;
      b_mag_q <= b_mag;
      // s2
      d_q     <= DOT_WIDTH'(ma_q) + DOT_WIDTH'(mb_q) + (DOT_WIDTH'(c1_q) <<< FRAC_SHIFT);
      a_hh_q  <= LHH_W'(a_mag_q[LINE_WIDTH-1:LINE_LO]) * LHH_W'(a_mag_q[LINE_WIDTH-1:LINE_LO]);
      a_hl_q  <= LHL_W'(a_mag_q[LINE_WIDTH-1:LINE_LO]) * LHL_W'(a_mag_q[LINE_LO-1:0]);
      a_ll_q  <= LLL_W'(a_mag_q[LINE_LO-1:0]) * LLL_W'(a_mag_q[LINE_LO-1:0]);
      b_hh_q  <= LHH_W'(b_mag_q[LINE_WIDTH-1:LINE_LO]) * LHH_W'(b_mag_q[LINE_WIDTH-1:LINE_LO]);
      b_hl_q  <= LHL_W'(b_mag_q[LINE_WIDTH-1:LINE_LO]) * LHL_W'(b_mag_q[LINE_LO-1:0]);
      b_ll_q  <= LLL_W'(b_mag_q[LINE_LO-1:0]) * LLL_W'(b_mag_q[LINE_LO-1:0]);
      // s3
      d_mag_q <= d_q[DOT_WIDTH-1] ? DOT_WIDTH'(-d_q) : DOT_WIDTH'(d_q);
      den3_q  <= DEN_WIDTH'(a_sq) + DEN_WIDTH'(b_sq);
      // s4
      d_hh_q  <= DHH_W'(d_mag_q[DOT_WIDTH-1:DOT_LO]) * DHH_W'(d_mag_q[DOT_WIDTH-1:DOT_LO]);
      d_hl_q  <= DHL_W'(d_mag_q[DOT_WIDTH-1:DOT_LO]) * DHL_W'(d_mag_q[DOT_LO-1:0]);
      d_ll_q  <= DLL_W'(d_mag_q[DOT_LO-1:0]) * DLL_W'(d_mag_q[DOT_LO-1:0]);
      den4_q  <= den3_q;
      deg4_q  <= den3_q == '0;
      // s5
      num_q   <= (NUM_WIDTH'(d_hh_q) << (2 * DOT_LO)) + (NUM_WIDTH'(d_hl_q) << (DOT_LO + 1))
               + NUM_WIDTH'(d_ll_q);
      den5_q  <= den4_q;
      deg5_q  <= deg4_q;
      // divider entry: saturation check
      rem_q[0] <= num_q;
      den_q[0] <= den5_q;
      quo_q[0] <= '0;
      sat_q[0] <= num_q >= (NUM_WIDTH'(den5_q) << ERR_WIDTH);
      deg_q[0] <= deg5_q;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar i = 1; i <= QUO_STEPS; i++) begin : g_div
    localparam int Shift = QUO_STEPS - i;
    logic [NUM_WIDTH-1:0] trial;
    logic                 take;

    assign trial = NUM_WIDTH'(den_q[i-1]) << Shift;
    assign take  = rem_q[i-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[i] <= quo_q[i-1] | (ERR_WIDTH'(take) << Shift);
        sat_q[i] <= sat_q[i-1];
        deg_q[i] <= deg_q[i-1];
      end
    end

    if (i < QUO_STEPS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= take ? rem_q[i-1] - trial : rem_q[i-1];
          den_q[i] <= den_q[i-1];
        end
      end
    end
  end

  // zero normal also lands here, since any numerator saturates
  assign res_o.err = sat_q[QUO_STEPS] ? '1 : quo_q[QUO_STEPS];
  assign res_o.deg = deg_q[QUO_STEPS];

endmodule

### hw/rtl/etx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etx_back
// runs both error lanes in lock step and holds the result register
// ----------------------------------------------------------------------------
module etx_back import etx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sym_i,
  input  queue_stat_t q_stat_i,
  input  job_t        q_data_i,
  output logic        q_pop_o,
  input  logic        out_pop_i,
  output logic        out_empty_o,
  output result_t     res_o
);

  `include "epipolar_transfer_error_macros.svh"

  logic [LANE_STAGES-1:0] vld_q;
  logic                   out_v_q;
  result_t                res_q;
  lane_res_t              r1, r0;
  logic                   adv, pick0;

  assign adv         = !out_v_q || out_pop_i;
  assign q_pop_o     = adv && !q_stat_i.empty;
  assign out_empty_o = !out_v_q;
  assign res_o       = res_q;

  etx_lane u_lane1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .in_i  (q_data_i.side1),
    .res_o (r1)
  );

  etx_lane u_lane0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .in_i  (q_data_i.side0),
    .res_o (r0)
  );

  // first image wins only on a strictly larger error
  assign pick0 = sym_i && (r0.err > r1.err);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      vld_q   <= {vld_q[LANE_STAGES-2:0], !q_stat_i.empty};
      out_v_q <= vld_q[LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.err  <= pick0 ? r0.err : r1.err;
      res_q.side <= !pick0;
      res_q.deg  <= r1.deg || (sym_i && r0.deg);
    end
  end

  `ETX_ASSERT_IMPL(side_one_when_plain, clk_i, rst_ni, out_v_q && !sym_i, res_q.side)
  `ETX_ASSERT_IMPL(degenerate_saturates, clk_i, rst_ni, out_v_q && res_q.deg, res_q.err == '1)
  `ETX_ASSERT_NEXT(stall_holds_result, clk_i, rst_ni, out_v_q && !out_pop_i, out_v_q && $stable(res_q))

endmodule

### verif/etx_error_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etx_error_checker
// watches the configuration port and both queue sides of the epipolar
// transfer error block, predicts the error of each correspondence and
// compares it field by field with each result transfer
// ----------------------------------------------------------------------------
module etx_error_checker import etx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COL_WIDTH-1:0]     cfg_data_i,
  input  logic                     push_i,
  input  logic                     full_i,
  input  coord_t                   x_first_i,
  input  coord_t                   y_first_i,
  input  coord_t                   x_second_i,
  input  coord_t                   y_second_i,
  input  logic                     pop_i,
  input  logic                     empty_i,
  input  logic [ERR_WIDTH-1:0]     sq_error_i,
  input  logic                     error_side_i,
  input  logic                     degenerate_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  logic signed [63:0] fmat [3][3];
  logic               sym_mode;
  result_t            expected_errors [$];

  // squared distance of a point to a line, floor of dot^2 / (a^2 + b^2)
  function automatic void point_line_error(input logic signed [63:0] a, b, c, px, py,
                                           output logic [ERR_WIDTH-1:0] err,
                                           output logic deg);
    logic signed [127:0] dot;
    logic [127:0]        num, den, quo;
    dot = 128'(a) * 128'(px) + 128'(b) * 128'(py) + 128'(c) * 128'sd16;
    num = dot * dot;
    den = 128'(a) * 128'(a) + 128'(b) * 128'(b);
    deg = 1'b0;
    if (den == '0) begin
      err = '1;
      deg = 1'b1;
    end else begin
      quo = num / den;
      err = (quo > 128'hFFFF_FFFF) ? '1 : quo[ERR_WIDTH-1:0];
    end
  endfunction

  function automatic result_t predict_error(input coord_t x1, y1, x2, y2);
    logic signed [63:0] p1 [3];
    logic signed [63:0] p2 [3];
    logic signed [63:0] ln [3];
    logic [ERR_WIDTH-1:0] e1, e0;
    logic                 d1, d0;
    result_t              res;
    p1[0] = 64'(x1); p1[1] = 64'(y1); p1[2] = 64'sd16;
    p2[0] = 64'(x2); p2[1] = 64'(y2); p2[2] = 64'sd16;
    // line in second image is F^T p1
    for (int c = 0; c < 3; c++) begin
      ln[c] = '0;
      for (int r = 0; r < 3; r++) ln[c] += fmat[r][c] * p1[r];
    end
    point_line_error(ln[0], ln[1], ln[2], p2[0], p2[1], e1, d1);
    res.err  = e1;
    res.side = 1'b1;
    res.deg  = d1;
    if (sym_mode) begin
      for (int r = 0; r < 3; r++) begin
        ln[r] = '0;
        for (int c = 0; c < 3; c++) ln[r] += fmat[r][c] * p2[c];
      end
      point_line_error(ln[0], ln[1], ln[2], p1[0], p1[1], e0, d0);
      res.deg = d1 | d0;
      // first image only wins when strictly larger
      if (e0 > e1) begin
        res.err  = e0;
        res.side = 1'b0;
      end
    end
    return res;
  endfunction

  assign pending_o = expected_errors.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) fmat[r][c] = '0;
      sym_mode = 1'b0;
      fail_count_o = 0;
      expected_errors.delete();
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_errors.size() == 0) begin
          $display("%0t: result transfer with nothing expected: err %h side %b deg %b",
                   $time, sq_error_i, error_side_i, degenerate_i);
          fail_count_o++;
        end else begin
          result_t exp_res;
          exp_res = expected_errors.pop_front();
          if (sq_error_i !== exp_res.err) begin
            $display("%0t: sq_error expected %h actual %h", $time, exp_res.err, sq_error_i);
            fail_count_o++;
          end
          if (error_side_i !== exp_res.side) begin
            $display("%0t: error_side expected %b actual %b", $time, exp_res.side,
                     error_side_i);
            fail_count_o++;
          end
          if (degenerate_i !== exp_res.deg) begin
            $display("%0t: degenerate expected %b actual %b", $time, exp_res.deg,
                     degenerate_i);
            fail_count_o++;
          end
        end
      end
      if (push_i && !full_i)
        expected_errors.insert(expected_errors.size(),
                               predict_error(x_first_i, y_first_i, x_second_i, y_second_i));
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_F_COL0, REG_F_COL1, REG_F_COL2: begin
            for (int r = 0; r < 3; r++)
              fmat[r][cfg_idx_i] = 64'(coef_t'(cfg_data_i[r*COEF_WIDTH +: COEF_WIDTH]));
          end
          REG_SYM_MODE: sym_mode = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### verif/epipolar_transfer_error_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epipolar_transfer_error_tb
// drives correspondences and matrix settings into the epipolar transfer
// error block under random idling on both sides; a checker beside the block
// predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module epipolar_transfer_error_tb;
  import etx_pkg::*;

  localparam int IDLE_PCT    = 18;
  localparam int WATCH_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [COL_WIDTH-1:0]     cfg_data_i;
  logic                     push;
  logic                     full;
  coord_t                   x_first_i, y_first_i, x_second_i, y_second_i;
  logic                     pop;
  logic                     empty;
  logic [ERR_WIDTH-1:0]     sq_error_o;
  logic                     error_side_o;
  logic                     degenerate_o;

  int  fail_count;
  int  pending;
  int  items_sent;
  bit  no_idle;
  int  idle_cycles;

  epipolar_transfer_error i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .x_first_i, .y_first_i, .x_second_i, .y_second_i,
    .pop, .empty, .sq_error_o, .error_side_o, .degenerate_o
  );

  etx_error_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i (push), .full_i (full),
    .x_first_i, .y_first_i, .x_second_i, .y_second_i,
    .pop_i (pop), .empty_i (empty),
    .sq_error_i (sq_error_o), .error_side_i (error_side_o), .degenerate_i (degenerate_o),
    .fail_count_o (fail_count), .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver idles at random except in the no-idle stretch
  always @(posedge clk_i) begin
    pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: cycles in which no transfer happens on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [COL_WIDTH-1:0] pack_col(coef_t e0, coef_t e1, coef_t e2);
    return {e2, e1, e0};
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(4))
      0:       return coef_t'($urandom);
      1, 2:    return coef_t'($urandom) >>> $urandom_range(4, 18);
      3:       return $urandom_range(1) ? coef_t'(20'h7FFFF) : coef_t'(20'h80000);
      default: return '0;
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return coord_t'(16'h7FFF);
      1:       return coord_t'(16'h8000);
      2, 3, 4: return coord_t'(int'($urandom_range(1023)) - 512);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // called on a clock edge; leaves the write enable high
  task automatic write_reg(cfg_reg_e idx, logic [COL_WIDTH-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_matrix(logic [COL_WIDTH-1:0] c0, c1, c2, logic sym);
    write_reg(REG_F_COL0, c0);
    write_reg(REG_F_COL1, c1);
    write_reg(REG_F_COL2, c2);
    write_reg(REG_SYM_MODE, COL_WIDTH'(sym));
    cfg_we_i <= 1'b0;
  endtask

  // one correspondence transfer, at times with a random gap ahead of it
  task automatic send_point(coord_t x1, y1, x2, y2);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push       <= 1'b1;
    x_first_i  <= x1;
    y_first_i  <= y1;
    x_second_i <= x2;
    y_second_i <= y2;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // hold the sender until every expected result has transferred
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    coef_t c0 [3], c1 [3], c2 [3];
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_F_COL0;
    cfg_data_i <= '0;
    push       <= 1'b0;
    x_first_i  <= '0;
    y_first_i  <= '0;
    x_second_i <= '0;
    y_second_i <= '0;
    pop        <= 1'b0;
    no_idle    = 1'b0;
    items_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset matrix is all zero: both lines degenerate, error saturates
    send_point(16'sh7FFF, 16'sh8000, '0, '0);
    send_point(16'sh1234, -16'sh0055, 16'sh7FFF, 16'sh7FFF);
    drain();
    set_matrix('0, '0, '0, 1'b1);
    // zero matrix in symmetric mode: saturated tie keeps the second image
    send_point(16'sh0100, 16'sh0200, -16'sh0300, 16'sh0400);
    drain();

    // symmetric matrix with equal points gives equal errors on both sides
    set_matrix(pack_col(20'sd300, -20'sd1200, 20'sd4500),
               pack_col(-20'sd1200, 20'sd700, -20'sd2100),
               pack_col(20'sd4500, -20'sd2100, 20'sd90000), 1'b1);
    send_point(16'sh0310, -16'sh0120, 16'sh0310, -16'sh0120);
    send_point(-16'sh2000, 16'sh0444, -16'sh2000, 16'sh0444);
    send_point(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_point(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    send_point('0, '0, '0, '0);
    drain();

    // first two columns zero: second-image line has no normal
    set_matrix('0, '0, pack_col(20'sd5, -20'sd7, 20'sd11), 1'b1);
    send_point(16'sh0050, 16'sh0060, 16'sh0070, 16'sh0080);
    send_point(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    drain();

    // first two rows zero: only the first-image line is degenerate
    set_matrix(pack_col('0, '0, 20'sd9), pack_col('0, '0, -20'sd13),
               pack_col('0, '0, 20'sd17), 1'b1);
    send_point(16'sh0050, 16'sh0060, 16'sh0070, 16'sh0080);
    drain();
    set_matrix(pack_col('0, '0, 20'sd9), pack_col('0, '0, -20'sd13),
               pack_col('0, '0, 20'sd17), 1'b0);
    send_point(16'sh0050, 16'sh0060, 16'sh0070, 16'sh0080);
    drain();

    // extreme coefficients, both signs
    set_matrix(pack_col(20'sh7FFFF, 20'sh80000, 20'sh7FFFF),
               pack_col(20'sh80000, 20'sh7FFFF, 20'sh80000),
               pack_col(20'sh7FFFF, 20'sh7FFFF, 20'sh80000), 1'b1);
    send_point(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_point(16'sh0001, -16'sh0001, 16'sh0010, 16'sh0000);
    send_point(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    drain();

    // random matrices, alternating modes, one phase without any idling
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 3; r++) begin
        c0[r] = rand_coef();
        c1[r] = rand_coef();
        c2[r] = rand_coef();
      end
      set_matrix(pack_col(c0[0], c0[1], c0[2]), pack_col(c1[0], c1[1], c1[2]),
                 pack_col(c2[0], c2[1], c2[2]), ph[0]);
      no_idle = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      drain();
      no_idle = 1'b0;
    end

    repeat (60) @(posedge clk_i);
    $display("sent %0d correspondences over zero, degenerate, tie, extreme and %0d random",
             items_sent, PHASES);
    $display("matrix settings in both modes, with random idling on input and result sides");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### epipolar_transfer_error.f
+incdir+hw/rtl
hw/rtl/etx_pkg.sv
hw/rtl/etx_front.sv
hw/rtl/etx_queue.sv
hw/rtl/etx_lane.sv
hw/rtl/etx_back.sv
hw/rtl/epipolar_transfer_error.sv
verif/etx_error_checker.sv
verif/epipolar_transfer_error_tb.sv
